/* rtl/multichannel_notch_biquad_cascade_unit_assert.svh */
// Assertion macros shared by the RTL.
`ifndef MULTICHANNEL_NOTCH_BIQUAD_CASCADE_UNIT_ASSERT_SVH
`define MULTICHANNEL_NOTCH_BIQUAD_CASCADE_UNIT_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication, sampled on clk, off during reset
`define MNBC_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mnbc: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset
`define MNBC_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mnbc: next-cycle check failed");

`else

`define MNBC_ASSERT_IMP(name, ante, cons)
`define MNBC_ASSERT_NXT(name, ante, cons)

`endif

`endif

/* rtl/mnbc_pkg.sv */
package mnbc_pkg;

  // Field and register types
  typedef logic        [3:0]  chan_t;
  typedef logic signed [23:0] sample_t;
  typedef logic signed [31:0] coef_t;
  typedef logic signed [31:0] hist_t;
  typedef logic        [2:0]  cfg_addr_t;
  typedef logic        [31:0] cfg_data_t;
  typedef logic        [2:0]  stage_cnt_t;

  // Register indexes on the configuration port
  typedef enum logic [2:0] {
    CFG_ENABLE = 3'd0,
    CFG_STAGES = 3'd1,
    CFG_B0     = 3'd2,
    CFG_B1     = 3'd3,
    CFG_B2     = 3'd4,
    CFG_A1     = 3'd5,
    CFG_A2     = 3'd6
  } cfg_idx_t;

  // One history entry: two past inputs, two past outputs (Q24.8)
  typedef struct packed {
    hist_t x1;
    hist_t x2;
    hist_t y1;
    hist_t y2;
  } hist_entry_t;

  // Product terms in order: b0*x, b1*x1, b2*x2, a1*y1, a2*y2
  typedef enum logic [2:0] {
    TERM_B0 = 3'd0,
    TERM_B1 = 3'd1,
    TERM_B2 = 3'd2,
    TERM_A1 = 3'd3,
    TERM_A2 = 3'd4
  } term_t;

  // Register reset values
  localparam logic       RST_ENABLE = 1'b1;
  localparam stage_cnt_t RST_STAGES = 3'd1;
  localparam coef_t      RST_B0     = 32'sd264247863;
  localparam coef_t      RST_B1     = 32'sd163316132;
  localparam coef_t      RST_B2     = 32'sd264247863;
  localparam coef_t      RST_A1     = 32'sd163316132;
  localparam coef_t      RST_A2     = 32'sd260057585;

  // Saturation limits
  localparam hist_t   HIST_MAX   = 32'sh7FFF_FFFF;
  localparam hist_t   HIST_MIN   = 32'sh8000_0000;
  localparam sample_t SAMPLE_MAX = 24'sh7F_FFFF;
  localparam sample_t SAMPLE_MIN = 24'sh80_0000;

endpackage

/* rtl/mnbc_in_if.sv */
// Sample input channel
interface mnbc_in_if;
  import mnbc_pkg::*;

  logic    valid;
  logic    ready;
  chan_t   channel_index;
  sample_t sample_in;

  modport source (output valid, output channel_index, output sample_in, input ready);
  modport sink   (input valid, input channel_index, input sample_in, output ready);
endinterface

/* rtl/mnbc_out_if.sv */
// Filtered sample output channel
interface mnbc_out_if;
  import mnbc_pkg::*;

  logic    valid;
  logic    ready;
  chan_t   channel_tag;
  sample_t sample_out;

  modport source (output valid, output channel_tag, output sample_out, input ready);
  modport sink   (input valid, input channel_tag, input sample_out, output ready);
endinterface

/* rtl/multichannel_notch_biquad_cascade_unit.sv */
// Multichannel cascaded biquad notch filter (direct form 1). Each accepted
// transaction carries one 24-bit sample of one channel; it runs through
// 1..MAX_STAGES biquad stages (stage_count register, 0 counts as 1) with
// Q3.28 coefficients and Q24.8 history, and leaves rounded and saturated
// to 24 bits with its channel tag. Disabled, or with a channel index not
// below CHANNELS, the sample passes straight through and no history moves.
// History of all stages and channels sits in one RAM of
// CHANNELS*MAX_STAGES entries; one shared 32x32 multiplier forms the five
// products of a stage, one per cycle. After reset and after every
// stage_count write the RAM is zeroed one entry per cycle, and no sample
// is accepted until that pass is done. A finished sample waits in the
// output register while the next is taken; only when that register is
// still full as the next sample finishes does the block hold the sample
// until the output side takes the older one.
`include "multichannel_notch_biquad_cascade_unit_assert.svh"

module multichannel_notch_biquad_cascade_unit #(
  parameter int CHANNELS   = 16,
  parameter int MAX_STAGES = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  mnbc_pkg::cfg_addr_t cfg_index,
  input  mnbc_pkg::cfg_data_t cfg_wdata,
  mnbc_in_if.sink             in_smp,
  mnbc_out_if.source          out_smp
);
  import mnbc_pkg::*;

  localparam int DEPTH = CHANNELS * MAX_STAGES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(MAX_STAGES + 1);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_MUL   = 6'b000100,
    S_SUM   = 6'b001000,
    S_ROUND = 6'b010000,
    S_FINAL = 6'b100000
  } state_t;

  state_t      state_r;
  logic [AW-1:0] clr_addr_r;
  logic [AW-1:0] addr_r;
  logic [CW-1:0] stages_left_r;
  term_t       term_r;

  // Configuration registers
  logic        enable_r;
  stage_cnt_t  stage_count_r;
  coef_t       b0_r, b1_r, b2_r, a1_r, a2_r;

  // Datapath registers
  chan_t               ch_r;
  hist_t               x_r;
  logic signed [63:0]  prod_r;
  logic                prod_vld_r;
  logic                prod_neg_r;
  logic signed [66:0]  acc_r;
  logic signed [66:0]  acc_nxt;
  logic                out_valid_r;
  chan_t               out_tag_r;
  sample_t             out_sample_r;

  // History RAM
  hist_entry_t         mem [DEPTH];
  hist_entry_t         rd_data_r;
  logic                mem_we;
  logic [AW-1:0]       mem_wa;
  hist_entry_t         mem_wd;
  logic                mem_re;
  logic [AW-1:0]       mem_ra;

  logic                in_acc;
  logic                filt;
  logic                out_load;
  logic                stage_wr;
  logic [CW-1:0]       eff_stages;
  coef_t               mul_a;
  hist_t               mul_b;
  logic signed [63:0]  mul_p;
  logic signed [66:0]  rnd;
  hist_t               y_sat;
  logic signed [32:0]  fin;
  sample_t             fin_sat;

  assign in_acc       = in_smp.valid && in_smp.ready;
  assign in_smp.ready = (state_r == S_IDLE);
  assign filt         = enable_r && (int'(in_smp.channel_index) < CHANNELS);

  // Output register takes a finished sample when empty or draining
  assign out_load = (state_r == S_FINAL) && (!out_valid_r || out_smp.ready);
  assign stage_wr = cfg_we && (cfg_index == CFG_STAGES);

  // Clamp stage count into 1..MAX_STAGES
  always_comb begin
    if (stage_count_r == '0) begin
      eff_stages = CW'(1);
    end else if (int'(stage_count_r) > MAX_STAGES) begin
      eff_stages = CW'(MAX_STAGES);
    end else begin
      eff_stages = CW'(stage_count_r);
    end
  end

  // Shared multiplier operand select
  always_comb begin
    unique case (term_r)
      TERM_B0: begin mul_a = b0_r; mul_b = x_r;          end
      TERM_B1: begin mul_a = b1_r; mul_b = rd_data_r.x1; end
      TERM_B2: begin mul_a = b2_r; mul_b = rd_data_r.x2; end
      TERM_A1: begin mul_a = a1_r; mul_b = rd_data_r.y1; end
      TERM_A2: begin mul_a = a2_r; mul_b = rd_data_r.y2; end
      default: begin mul_a = '0;   mul_b = '0;           end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Accumulate the previous product; feedback terms subtract
  always_comb begin
    acc_nxt = acc_r;
    if (prod_vld_r) begin
      if (prod_neg_r) begin
        acc_nxt = acc_r - 67'(prod_r);
      end else begin
        acc_nxt = acc_r + 67'(prod_r);
      end
    end
  end

  // Round half up to Q24.8 and saturate to 32 bits
  assign rnd = acc_r + (67'sd1 <<< 27);
  always_comb begin
    if (&rnd[66:59] || ~|rnd[66:59]) begin
      y_sat = rnd[59:28];
    end else if (rnd[66]) begin
      y_sat = HIST_MIN;
    end else begin
      y_sat = HIST_MAX;
    end
  end

  // Round half up back to an integer sample and saturate to 24 bits
  assign fin = {x_r[31], x_r} + 33'sd128;
  always_comb begin
    if (fin[32] == fin[31]) begin
      fin_sat = fin[31:8];
    end else if (fin[32]) begin
      fin_sat = SAMPLE_MIN;
    end else begin
      fin_sat = SAMPLE_MAX;
    end
  end

  // RAM port control
  always_comb begin
    mem_we    = (state_r == S_CLEAR) || (state_r == S_ROUND);
    mem_wa    = (state_r == S_CLEAR) ? clr_addr_r : addr_r;
    mem_wd    = '0;
    if (state_r == S_ROUND) begin
      mem_wd.x1 = x_r;
      mem_wd.x2 = rd_data_r.x1;
      mem_wd.y1 = y_sat;
      mem_wd.y2 = rd_data_r.y1;
    end
    mem_re = (in_acc && filt) || ((state_r == S_ROUND) && (stages_left_r != CW'(1)));
    mem_ra = (state_r == S_IDLE) ? AW'(in_smp.channel_index) : addr_r + AW'(CHANNELS);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_ra];
    end
  end

  // Sequencer, configuration and datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      clr_addr_r    <= '0;
      out_valid_r   <= 1'b0;
      prod_vld_r    <= 1'b0;
      term_r        <= TERM_B0;
      enable_r      <= RST_ENABLE;
      stage_count_r <= RST_STAGES;
      b0_r          <= RST_B0;
      b1_r          <= RST_B1;
      b2_r          <= RST_B2;
      a1_r          <= RST_A1;
      a2_r          <= RST_A2;
    end else begin
      // Output valid: a load wins over a drain
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_smp.ready) begin
        out_valid_r <= 1'b0;
      end

      if (stage_wr) begin
        // a stage count write restarts the clearing pass
        state_r    <= S_CLEAR;
        clr_addr_r <= '0;
      end else begin
        unique case (state_r)
          S_CLEAR: begin
            clr_addr_r <= clr_addr_r + AW'(1);
            if (clr_addr_r == AW'(DEPTH - 1)) begin
              state_r <= S_IDLE;
            end
          end
          S_IDLE: begin
            if (in_acc) begin
              ch_r          <= in_smp.channel_index;
              x_r           <= {in_smp.sample_in, 8'h00};
              addr_r        <= AW'(in_smp.channel_index);
              stages_left_r <= eff_stages;
              term_r        <= TERM_B0;
              prod_vld_r    <= 1'b0;
              acc_r         <= '0;
              state_r       <= filt ? S_MUL : S_FINAL;
            end
          end
          S_MUL: begin
            prod_r     <= mul_p;
            prod_neg_r <= (term_r == TERM_A1) || (term_r == TERM_A2);
            prod_vld_r <= 1'b1;
            acc_r      <= acc_nxt;
            term_r     <= term_t'(term_r + 3'd1);
            if (term_r == TERM_A2) begin
              state_r <= S_SUM;
            end
          end
          S_SUM: begin
            acc_r   <= acc_nxt;
            state_r <= S_ROUND;
          end
          S_ROUND: begin
            // stage output feeds the next stage
            x_r           <= y_sat;
            addr_r        <= addr_r + AW'(CHANNELS);
            stages_left_r <= stages_left_r - CW'(1);
            acc_r         <= '0;
            prod_vld_r    <= 1'b0;
            term_r        <= TERM_B0;
            state_r       <= (stages_left_r == CW'(1)) ? S_FINAL : S_MUL;
          end
          S_FINAL: begin
            if (out_load) begin
              out_tag_r    <= ch_r;
              out_sample_r <= fin_sat;
              state_r      <= S_IDLE;
            end
          end
          default: state_r <= S_IDLE;
        endcase
      end

      // Register writes
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ENABLE: enable_r <= cfg_wdata[0];
          CFG_STAGES: stage_count_r <= cfg_wdata[2:0];
          CFG_B0:  b0_r <= cfg_wdata;
          CFG_B1:  b1_r <= cfg_wdata;
          CFG_B2:  b2_r <= cfg_wdata;
          CFG_A1:  a1_r <= cfg_wdata;
          CFG_A2:  a2_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  assign out_smp.valid       = out_valid_r;
  assign out_smp.channel_tag = out_tag_r;
  assign out_smp.sample_out  = out_sample_r;

  // Checks
  `MNBC_ASSERT_NXT(a_bypass_to_final, in_acc && !filt && !cfg_we, state_r == S_FINAL)
  `MNBC_ASSERT_IMP(a_stage_left_nonzero, state_r == S_MUL, stages_left_r != '0)
  `MNBC_ASSERT_NXT(a_stage_write_clears, stage_wr, (state_r == S_CLEAR) && (clr_addr_r == '0))
  `MNBC_ASSERT_IMP(a_out_from_final, $rose(out_valid_r), $past(state_r == S_FINAL))

endmodule

/* bench/multichannel_notch_biquad_cascade_unit_tb.sv */
module multichannel_notch_biquad_cascade_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mnbc_pkg::*;

  localparam int CHANNELS     = 16;
  localparam int MAX_STAGES   = 4;
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 150;
  localparam int TAIL_CYCLES  = 64;
  localparam int TIMEOUT_NS   = 1_000_000;
  localparam int REPORT_LINES = 100;

  // index 7 is not a register; writes to it must change nothing
  localparam cfg_addr_t CFG_UNUSED = 3'd7;

  localparam coef_t COEF_MAX  = 32'sh7FFF_FFFF;
  localparam coef_t COEF_MIN  = 32'sh8000_0000;
  localparam coef_t COEF_UNIT = 32'sh1000_0000;

  typedef struct {
    chan_t   tag;
    sample_t value;
  } filtered_sample_t;

  logic      clk;
  logic      rst_n;
  logic      cfg_we;
  cfg_addr_t cfg_index;
  cfg_data_t cfg_wdata;

  mnbc_in_if  in_bus ();
  mnbc_out_if out_bus ();

  multichannel_notch_biquad_cascade_unit #(
    .CHANNELS  (CHANNELS),
    .MAX_STAGES(MAX_STAGES)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_smp   (in_bus),
    .out_smp  (out_bus)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Filter model: register copy and per stage/channel history
  logic       flt_enable;
  stage_cnt_t flt_stages;
  coef_t      flt_b0, flt_b1, flt_b2, flt_a1, flt_a2;
  hist_t      hist_x1 [CHANNELS*MAX_STAGES];
  hist_t      hist_x2 [CHANNELS*MAX_STAGES];
  hist_t      hist_y1 [CHANNELS*MAX_STAGES];
  hist_t      hist_y2 [CHANNELS*MAX_STAGES];

  filtered_sample_t pending_samples[$];
  int unsigned      mismatch_count = 0;
  int unsigned      idle_rate = 4;   // 0: no idling, else 1 chance in idle_rate

  function automatic void clear_history();
    for (int i = 0; i < CHANNELS*MAX_STAGES; i++) begin
      hist_x1[i] = '0;
      hist_x2[i] = '0;
      hist_y1[i] = '0;
      hist_y2[i] = '0;
    end
  endfunction

  function automatic void reset_filter_model();
    flt_enable = RST_ENABLE;
    flt_stages = RST_STAGES;
    flt_b0     = RST_B0;
    flt_b1     = RST_B1;
    flt_b2     = RST_B2;
    flt_a1     = RST_A1;
    flt_a2     = RST_A2;
    clear_history();
  endfunction

  function automatic void apply_reg(cfg_addr_t idx, cfg_data_t val);
    case (idx)
      CFG_ENABLE: flt_enable = val[0];
      CFG_STAGES: begin
        flt_stages = val[2:0];
        clear_history();
      end
      CFG_B0: flt_b0 = coef_t'(val);
      CFG_B1: flt_b1 = coef_t'(val);
      CFG_B2: flt_b2 = coef_t'(val);
      CFG_A1: flt_a1 = coef_t'(val);
      CFG_A2: flt_a2 = coef_t'(val);
      default: ;
    endcase
  endfunction

  // One biquad: exact sum of the five products, round half up to Q24.8, saturate
  function automatic hist_t biquad_stage(int slot, hist_t x);
    logic signed [71:0] acc;
    hist_t              y;
    acc = flt_b0 * x + flt_b1 * hist_x1[slot] + flt_b2 * hist_x2[slot]
        - flt_a1 * hist_y1[slot] - flt_a2 * hist_y2[slot] + 72'sd134217728;
    acc = acc >>> 28;
    if (acc > HIST_MAX) y = HIST_MAX;
    else if (acc < HIST_MIN) y = HIST_MIN;
    else y = acc[31:0];
    hist_x2[slot] = hist_x1[slot];
    hist_x1[slot] = x;
    hist_y2[slot] = hist_y1[slot];
    hist_y1[slot] = y;
    return y;
  endfunction

  function automatic sample_t filter_sample(chan_t ch, sample_t smp);
    hist_t              v;
    int                 n;
    logic signed [39:0] r;
    if (!flt_enable || int'(ch) >= CHANNELS) return smp;
    if (flt_stages == 0) n = 1;
    else if (flt_stages > MAX_STAGES) n = MAX_STAGES;
    else n = flt_stages;
    v = {smp, 8'h00};
    for (int st = 0; st < n; st++) v = biquad_stage(st * CHANNELS + int'(ch), v);
    r = v;
    r = (r + 40'sd128) >>> 8;
    if (r > SAMPLE_MAX) return SAMPLE_MAX;
    if (r < SAMPLE_MIN) return SAMPLE_MIN;
    return r[23:0];
  endfunction

  task automatic report_mismatch(string what);
    if (mismatch_count < REPORT_LINES) $display("mismatch at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Send one sample transaction; the expectation is queued before acceptance
  task automatic send_sample(chan_t ch, sample_t smp);
    filtered_sample_t want;
    if (idle_rate != 0 && $urandom_range(1, idle_rate) == 1) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    want.tag   = ch;
    want.value = filter_sample(ch, smp);
    pending_samples.push_back(want);
    in_bus.valid         <= 1'b1;
    in_bus.channel_index <= ch;
    in_bus.sample_in     <= smp;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  // Drop valid and wait for every queued result
  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (pending_samples.size() != 0);
  endtask

  task automatic write_reg(cfg_addr_t idx, cfg_data_t val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    apply_reg(idx, val);
  endtask

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2, 3:    return sample_t'($urandom_range(0, 511) - 256);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // mode 0: reset value, 1: -0.5 <= c < 0.5, 2: any, 3: corner values or any
  function automatic coef_t pick_coef(int unsigned mode, coef_t dflt);
    case (mode)
      0: return dflt;
      1: return coef_t'($urandom_range(0, 28'hFFF_FFFF) - 32'h0800_0000);
      2: return coef_t'($urandom);
      default: begin
        case ($urandom_range(0, 5))
          0:       return COEF_MAX;
          1:       return COEF_MIN;
          2:       return COEF_UNIT;
          3:       return '0;
          4:       return '1;
          default: return coef_t'($urandom);
        endcase
      end
    endcase
  endfunction

  // Result checker: each accepted result against the oldest expectation
  always @(posedge clk) begin : check_results
    filtered_sample_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_samples.size() == 0) begin
        report_mismatch($sformatf("unexpected result ch %0d sample %0d",
                                  out_bus.channel_tag, out_bus.sample_out));
      end else begin
        want = pending_samples.pop_front();
        if (out_bus.channel_tag !== want.tag)
          report_mismatch($sformatf("channel_tag %0d, expected %0d",
                                    out_bus.channel_tag, want.tag));
        if (out_bus.sample_out !== want.value)
          report_mismatch($sformatf("sample_out %0d, expected %0d (ch %0d)",
                                    out_bus.sample_out, want.value, want.tag));
      end
    end
  end

  // Result side back-pressure in bursts
  initial begin : result_sink
    out_bus.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (idle_rate != 0 && $urandom_range(1, 2 * idle_rate) == 1) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Reset values, sample extremes and both channel ends
  task automatic test_reset_defaults();
    send_sample(4'd0, SAMPLE_MAX);
    send_sample(4'd0, SAMPLE_MAX);
    send_sample(4'd0, SAMPLE_MIN);
    send_sample(4'd15, SAMPLE_MIN);
    send_sample(4'd15, '0);
    send_sample(4'd3, '1);
    send_sample(4'd3, 24'sd1);
    send_sample(4'd15, SAMPLE_MAX);
  endtask

  // Disabled block passes samples and keeps history; unused index is inert
  task automatic test_passthrough();
    wait_idle();
    write_reg(CFG_UNUSED, '0);
    send_sample(4'd7, 24'sd4000);
    wait_idle();
    write_reg(CFG_ENABLE, 32'hFFFF_FFFE);
    send_sample(4'd7, SAMPLE_MAX);
    send_sample(4'd7, SAMPLE_MIN);
    wait_idle();
    write_reg(CFG_ENABLE, 32'h0000_0001);
    send_sample(4'd7, 24'sd12345);
  endtask

  // Stage count zero counts as one, above the maximum as the maximum
  task automatic test_stage_limits();
    wait_idle();
    write_reg(CFG_STAGES, 32'h0000_0000);
    send_sample(4'd2, 24'sd100000);
    send_sample(4'd2, -24'sd100000);
    wait_idle();
    write_reg(CFG_STAGES, 32'hFFFF_FFFF);
    send_sample(4'd9, SAMPLE_MAX);
    send_sample(4'd9, 24'sd77);
  endtask

  // Corner coefficients drive history and output into saturation
  task automatic test_extreme_coefs();
    wait_idle();
    write_reg(CFG_B0, COEF_MAX);
    write_reg(CFG_B1, COEF_MIN);
    write_reg(CFG_B2, COEF_MAX);
    write_reg(CFG_A1, COEF_MIN);
    write_reg(CFG_A2, COEF_MAX);
    write_reg(CFG_STAGES, 32'd2);
    send_sample(4'd11, SAMPLE_MAX);
    send_sample(4'd11, SAMPLE_MIN);
    send_sample(4'd11, SAMPLE_MAX);
    send_sample(4'd11, SAMPLE_MIN);
    send_sample(4'd4, SAMPLE_MAX);
  endtask

  // Random settings per phase, random traffic with channel runs
  task automatic test_random_phases();
    int unsigned mode;
    chan_t       run_ch;
    chan_t       ch;
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      case ($urandom_range(0, 3))
        0: idle_rate = 0;
        1: idle_rate = 2;
        2: idle_rate = 3;
        default: idle_rate = 6;
      endcase
      if (ph == PHASES - 1) idle_rate = 0;
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4:          mode = 0;
        5, 6, 7, 8, 9, 10, 11:  mode = 1;
        12, 13, 14:             mode = 2;
        default:                mode = 3;
      endcase
      if ($urandom_range(0, 3) != 0)
        write_reg(CFG_ENABLE, ($urandom & 32'hFFFF_FFFE) | ($urandom_range(0, 4) != 0));
      if ($urandom_range(0, 3) != 0) write_reg(CFG_B0, pick_coef(mode, RST_B0));
      if ($urandom_range(0, 3) != 0) write_reg(CFG_B1, pick_coef(mode, RST_B1));
      if ($urandom_range(0, 3) != 0) write_reg(CFG_B2, pick_coef(mode, RST_B2));
      if ($urandom_range(0, 3) != 0) write_reg(CFG_A1, pick_coef(mode, RST_A1));
      if ($urandom_range(0, 3) != 0) write_reg(CFG_A2, pick_coef(mode, RST_A2));
      // stage count last: its write clears history; sometimes history carries over
      if ($urandom_range(0, 2) != 0)
        write_reg(CFG_STAGES, ($urandom & 32'hFFFF_FFF8) | $urandom_range(0, 7));
      run_ch = chan_t'($urandom_range(0, CHANNELS - 1));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 7) == 0) run_ch = chan_t'($urandom_range(0, CHANNELS - 1));
        ch = ($urandom_range(0, 1) == 0) ? run_ch : chan_t'($urandom_range(0, CHANNELS - 1));
        send_sample(ch, pick_sample());
      end
    end
  endtask

  initial begin : stimulus
    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_index            <= CFG_ENABLE;
    cfg_wdata            <= '0;
    in_bus.valid         <= 1'b0;
    in_bus.channel_index <= '0;
    in_bus.sample_in     <= '0;
    reset_filter_model();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_passthrough();
    test_stage_limits();
    test_extreme_coefs();
    test_random_phases();

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_samples.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_samples.size()));
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
